>>> rtl/core/lcd4_pkg.sv
// shared types, command codes and helpers for the 4-bit character lcd interface
// no dependencies
package lcd4_pkg;

  typedef enum logic [2:0] {
    FUNC_INIT    = 3'd0,
    FUNC_CHAR    = 3'd1,
    FUNC_WRAP    = 3'd2,
    FUNC_GOTO    = 3'd3,
    FUNC_CLEAR   = 3'd4,
    FUNC_CURSOR  = 3'd5,
    FUNC_DISPLAY = 3'd6,
    FUNC_RESTART = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    CFG_LINE_COUNT   = 2'd0,
    CFG_CHARS        = 2'd1,
    CFG_STROBE_TICKS = 2'd2,
    CFG_CLEAR_TICKS  = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] DDRAM_SET   = 8'h80;
  localparam logic [6:0] ROW_STEP    = 7'h40;
  localparam logic [6:0] ROW_SKEW    = 7'h14;
  localparam logic [7:0] CMD_FSET    = 8'h20;
  localparam logic [7:0] FSET_LINES  = 8'h08;
  localparam logic [7:0] CMD_ENTRY   = 8'h06;
  localparam logic [7:0] CMD_DISP_ON = 8'h0C;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_CURSOR  = 8'h0E;
  localparam logic [7:0] CMD_DISP    = 8'h08;
  localparam logic [3:0] NIB_WAKE    = 4'h3;
  localparam logic [3:0] NIB_4BIT    = 4'h2;

  // index of the final nibble of a job
  localparam logic [3:0] LAST_INIT = 4'd11;
  localparam logic [3:0] LAST_ONE  = 4'd1;
  localparam logic [3:0] LAST_TWO  = 4'd3;

  // one decoded request as queued between front and back
  typedef struct packed {
    logic       init;
    logic [3:0] last_idx;
    logic [7:0] b0;
    logic       rs0;
    logic [7:0] b1;
    logic       clr_wait;
  } desc_t;

  typedef struct packed {
    logic multi;
    logic four;
  } lines_t;

  function automatic lines_t lines_of(logic [2:0] line_count);
    lines_t l;
    l.four  = (line_count == 3'd4);
    l.multi = (line_count == 3'd2) || l.four;
    return l;
  endfunction

  function automatic logic [7:0] goto_cmd(lines_t l, logic [5:0] col, logic [1:0] row);
    logic [6:0] base;
    base = 7'h00;
    if (l.four) begin
      case (row)
        2'd0:    base = 7'h00;
        2'd1:    base = ROW_STEP;
        2'd2:    base = ROW_SKEW;
        default: base = ROW_STEP + ROW_SKEW;
      endcase
    end else if (l.multi) begin
      base = row[0] ? ROW_STEP : 7'h00;
    end
    return DDRAM_SET | {1'b0, base + {1'b0, col}};
  endfunction

endpackage

>>> rtl/core/lcd4_front.sv
// request decoder: accepts requests, keeps cursor flags and wrap counters,
// and builds one job descriptor per request; uses lcd4_pkg
module lcd4_front import lcd4_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [2:0] line_count_i,
  input  logic [5:0] chars_per_line_i,
  input  logic       req_fire_i,
  input  logic [2:0] func_i,
  input  logic [7:0] char_code_i,
  input  logic [5:0] column_i,
  input  logic [1:0] row_i,
  input  logic       cursor_enable_i,
  input  logic       cursor_blink_i,
  input  logic       display_enable_i,
  output desc_t      desc_o
);

  logic       shown_q, shown_d;
  logic       blink_q, blink_d;
  logic [5:0] wcol_q, wcol_d;
  logic [1:0] wrow_q, wrow_d;

  lines_t     lines;
  logic [5:0] col_inc;
  logic [1:0] row_inc;
  logic [1:0] row_next;

  always_comb begin
    lines   = lines_of(line_count_i);
    col_inc = wcol_q + 6'd1;
    row_inc = wrow_q + 2'd1;
    if (lines.four) begin
      row_next = row_inc;
    end else if (lines.multi) begin
      row_next = {1'b0, row_inc[0]};
    end else begin
      row_next = 2'd0;
    end

    shown_d = shown_q;
    blink_d = blink_q;
    wcol_d  = wcol_q;
    wrow_d  = wrow_q;

    desc_o.init     = 1'b0;
    desc_o.last_idx = LAST_ONE;
    desc_o.b0       = 8'h00;
    desc_o.rs0      = 1'b0;
    desc_o.b1       = 8'h00;
    desc_o.clr_wait = 1'b0;

    case (func_e'(func_i))
      FUNC_INIT: begin
        desc_o.init     = 1'b1;
        desc_o.last_idx = LAST_INIT;
        desc_o.b0       = lines.multi ? (CMD_FSET | FSET_LINES) : CMD_FSET;
        desc_o.clr_wait = 1'b1;
        shown_d = 1'b0;
        blink_d = 1'b0;
        wcol_d  = 6'd0;
        wrow_d  = 2'd0;
      end
      FUNC_CHAR: begin
        desc_o.b0  = char_code_i;
        desc_o.rs0 = 1'b1;
      end
      FUNC_WRAP: begin
        desc_o.b0  = char_code_i;
        desc_o.rs0 = 1'b1;
        // a zero wrap point always wraps, as the compare below gives
        if (col_inc >= chars_per_line_i) begin
          wcol_d          = 6'd0;
          wrow_d          = row_next;
          desc_o.last_idx = LAST_TWO;
          desc_o.b1       = goto_cmd(lines, 6'd0, row_next);
        end else begin
          wcol_d = col_inc;
        end
      end
      FUNC_GOTO: begin
        desc_o.b0 = goto_cmd(lines, column_i, row_i);
      end
      FUNC_CLEAR: begin
        desc_o.b0       = CMD_CLEAR;
        desc_o.clr_wait = 1'b1;
      end
      FUNC_CURSOR: begin
        if (cursor_enable_i) begin
          desc_o.b0 = CMD_CURSOR | {7'd0, cursor_blink_i};
          shown_d   = 1'b1;
          blink_d   = cursor_blink_i;
        end else begin
          desc_o.b0 = CMD_DISP_ON;
          shown_d   = 1'b0;
          blink_d   = 1'b0;
        end
      end
      FUNC_DISPLAY: begin
        desc_o.b0 = CMD_DISP | {5'd0, display_enable_i, shown_q, blink_q};
      end
      FUNC_RESTART: begin
        desc_o.b0 = goto_cmd(lines, 6'd0, 2'd0);
        wcol_d    = 6'd0;
        wrow_d    = 2'd0;
      end
      default: begin
        desc_o.b0 = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q <= 1'b0;
      blink_q <= 1'b0;
      wcol_q  <= 6'd0;
      wrow_q  <= 2'd0;
    end else if (req_fire_i) begin
      shown_q <= shown_d;
      blink_q <= blink_d;
      wcol_q  <= wcol_d;
      wrow_q  <= wrow_d;
    end
  end

endmodule

>>> rtl/core/lcd4_fifo.sv
// two-entry job queue between request decoder and nibble sequencer
// uses desc_t from lcd4_pkg
module lcd4_fifo import lcd4_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  input  logic  pop_i,
  output desc_t head_o,
  output logic  empty_o,
  output logic  full_o
);

  desc_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

>>> rtl/core/lcd4_back.sv
// nibble sequencer: walks the head job one nibble per cycle, unless the output
// stalls, into an output register; uses lcd4_pkg
module lcd4_back import lcd4_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  desc_t      head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [3:0] nibble, rest zero
  output logic [1:0] m_axis_tuser,  // [0] register_select, [1] extra_wait
  output logic       m_axis_tlast
);

  logic [3:0] idx_q, idx_d;
  logic       vld_q;
  logic [3:0] nib_q, nib_d;
  logic       rs_q, rs_d;
  logic       wt_q, wt_d;
  logic       last_q, last_d;
  logic       adv;
  logic [7:0] byte_sel;

  assign adv   = !empty_i && (!vld_q || m_axis_tready);
  assign pop_o = adv && last_d;

  always_comb begin
    last_d = (idx_q == head_i.last_idx);
    wt_d   = last_d && head_i.clr_wait;
    rs_d   = 1'b0;
    if (head_i.init) begin
      case (idx_q)
        4'd4, 4'd5:   byte_sel = head_i.b0;
        4'd6, 4'd7:   byte_sel = CMD_ENTRY;
        4'd8, 4'd9:   byte_sel = CMD_DISP_ON;
        default:      byte_sel = CMD_CLEAR;
      endcase
    end else begin
      byte_sel = (idx_q < 4'd2) ? head_i.b0 : head_i.b1;
      rs_d     = (idx_q < 4'd2) && head_i.rs0;
    end
    // even step sends the high nibble, odd step the low one
    nib_d = idx_q[0] ? byte_sel[3:0] : byte_sel[7:4];
    if (head_i.init && (idx_q < 4'd4)) begin
      nib_d = (idx_q == 4'd3) ? NIB_4BIT : NIB_WAKE;
    end
    idx_d = last_d ? 4'd0 : idx_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 4'd0;
      vld_q <= 1'b0;
    end else begin
      if (adv) begin
        idx_q <= idx_d;
        vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nib_q  <= nib_d;
      rs_q   <= rs_d;
      wt_q   <= wt_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {4'd0, nib_q};
  assign m_axis_tuser  = {wt_q, rs_q};
  assign m_axis_tlast  = last_q;

endmodule

>>> rtl/core/char_lcd_4bit_interface.sv
// top level of the 4-bit character lcd interface: config registers,
// request decoder, job queue and nibble sequencer; uses lcd4_pkg and submodules
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser func, tdata char/column/row/flags
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata nibble, tuser rs/wait, tlast
// cfg       in   cfg_we_i                      cfg_index_i, cfg_wdata_i
//
// one request is taken per cycle while the two-entry job queue has room
// each request gives 2, 4 or 12 nibbles, one per cycle from the sequencer unless the output stalls
// so sustained request throughput is set by the sequencer
// a stalled output holds its register; the queue keeps accepting until full
// reset clears queue, sequencer, cursor flags and wrap counters at once
// strobe and clear-wait tick counts are not stored
module char_lcd_4bit_interface import lcd4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] char_code, [13:8] column, [15:14] row, [16] cursor_enable,
  // [17] cursor_blink, [18] display_enable, rest zero
  input  logic [23:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,   // [2:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] nibble, rest zero
  output logic [1:0]  m_axis_tuser,   // [0] register_select, [1] extra_wait
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_wdata_i
);

  logic [2:0] line_count_q;
  logic [5:0] chars_q;
  logic       in_fire;
  desc_t      new_desc, head;
  logic       q_empty, q_full, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= 3'd2;
      chars_q      <= 6'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LINE_COUNT: line_count_q <= cfg_wdata_i[2:0];
        CFG_CHARS:      chars_q      <= cfg_wdata_i[5:0];
        default:        ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  lcd4_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .line_count_i     (line_count_q),
    .chars_per_line_i (chars_q),
    .req_fire_i       (in_fire),
    .func_i           (s_axis_tuser),
    .char_code_i      (s_axis_tdata[7:0]),
    .column_i         (s_axis_tdata[13:8]),
    .row_i            (s_axis_tdata[15:14]),
    .cursor_enable_i  (s_axis_tdata[16]),
    .cursor_blink_i   (s_axis_tdata[17]),
    .display_enable_i (s_axis_tdata[18]),
    .desc_o           (new_desc)
  );

  lcd4_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_data_i (new_desc),
    .pop_i       (q_pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  lcd4_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clear wait only ever trails the low nibble of a clear command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tlast && !m_axis_tuser[0] && (m_axis_tdata == 8'h01))
    else $error("extra wait on a beat other than the end of a clear");

  // a fresh output beat needs a job in the queue the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!q_empty))
    else $error("output beat without a queued job");

  // queue only fills through an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(q_full) |-> $past(in_fire))
    else $error("queue filled without a request");

  // a pop never happens on an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty job queue");

endmodule

>>> tb/tb_top.sv
// self-checking bench for char_lcd_4bit_interface: random and directed lcd requests,
// predicted nibble strobes checked beat by beat; depends on lcd4_pkg and the rtl top
module tb_top;
  import lcd4_pkg::*;

  typedef struct {
    func_e      func;
    logic [7:0] ch;
    logic [5:0] col;
    logic [1:0] row;
    logic       cen;
    logic       cbl;
    logic       den;
  } lcd_req_t;

  typedef struct {
    logic [3:0] nibble;
    logic       rs;
    logic       clr_wait;
    logic       is_last;
  } strobe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [19:0] cfg_wdata_i = '0;

  char_lcd_4bit_interface u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  lcd_req_t pending_q[$];
  strobe_t  strobe_q[$];

  // predictor copy of the block's registers and state
  logic [2:0]  exp_lines = 3'd2;
  logic [5:0]  exp_chars = 6'd16;
  logic        exp_shown = 1'b0;
  logic        exp_blink = 1'b0;
  logic [5:0]  exp_col = '0;
  logic [1:0]  exp_row = '0;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_left = 0;
  int err_cnt = 0;
  bit req_taken = 1'b0;
  strobe_t got_exp;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int line_span();
    if (exp_lines == 3'd2) return 2;
    if (exp_lines == 3'd4) return 4;
    return 1;
  endfunction

  function automatic logic [7:0] ddram_addr(logic [5:0] col, logic [1:0] row);
    logic [7:0] base;
    base = 8'h00;
    if (line_span() == 2) begin
      base = row[0] ? 8'h40 : 8'h00;
    end else if (line_span() == 4) begin
      case (row)
        2'd0:    base = 8'h00;
        2'd1:    base = 8'h40;
        2'd2:    base = 8'h14;
        default: base = 8'h54;
      endcase
    end
    return 8'h80 | ((base + {2'b00, col}) & 8'h7F);
  endfunction

  function automatic void push_nibble(logic [3:0] nib, logic rs, logic clr_wait);
    strobe_t s;
    s.nibble   = nib;
    s.rs       = rs;
    s.clr_wait = clr_wait;
    s.is_last  = 1'b0;
    strobe_q.push_back(s);
  endfunction

  function automatic void push_byte(logic [7:0] b, logic rs, logic clr_wait);
    push_nibble(b[7:4], rs, 1'b0);
    push_nibble(b[3:0], rs, clr_wait);
  endfunction

  function automatic void predict_strobes(lcd_req_t r);
    case (r.func)
      FUNC_INIT: begin
        push_nibble(NIB_WAKE, 1'b0, 1'b0);
        push_nibble(NIB_WAKE, 1'b0, 1'b0);
        push_nibble(NIB_WAKE, 1'b0, 1'b0);
        push_nibble(NIB_4BIT, 1'b0, 1'b0);
        push_byte(CMD_FSET | ((line_span() > 1) ? FSET_LINES : 8'h00), 1'b0, 1'b0);
        push_byte(CMD_ENTRY, 1'b0, 1'b0);
        push_byte(CMD_DISP_ON, 1'b0, 1'b0);
        push_byte(CMD_CLEAR, 1'b0, 1'b1);
        exp_shown = 1'b0;
        exp_blink = 1'b0;
        exp_col   = '0;
        exp_row   = '0;
      end
      FUNC_CHAR: push_byte(r.ch, 1'b1, 1'b0);
      FUNC_WRAP: begin
        push_byte(r.ch, 1'b1, 1'b0);
        exp_col = exp_col + 6'd1;
        if (exp_col >= exp_chars) begin
          exp_col = '0;
          exp_row = 2'((int'(exp_row) + 1) % line_span());
          push_byte(ddram_addr(6'd0, exp_row), 1'b0, 1'b0);
        end
      end
      FUNC_GOTO:  push_byte(ddram_addr(r.col, r.row), 1'b0, 1'b0);
      FUNC_CLEAR: push_byte(CMD_CLEAR, 1'b0, 1'b1);
      FUNC_CURSOR: begin
        if (r.cen) begin
          push_byte(CMD_CURSOR | {7'd0, r.cbl}, 1'b0, 1'b0);
          exp_shown = 1'b1;
          exp_blink = r.cbl;
        end else begin
          push_byte(CMD_DISP_ON, 1'b0, 1'b0);
          exp_shown = 1'b0;
          exp_blink = 1'b0;
        end
      end
      FUNC_DISPLAY: push_byte(CMD_DISP | {5'd0, r.den, exp_shown, exp_blink}, 1'b0, 1'b0);
      default: begin
        push_byte(ddram_addr(6'd0, 2'd0), 1'b0, 1'b0);
        exp_col = '0;
        exp_row = '0;
      end
    endcase
    strobe_q[strobe_q.size() - 1].is_last = 1'b1;
  endfunction

  function automatic void note_error(string msg);
    if (err_cnt < 10) $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endfunction

  // request driver: holds a beat until taken, otherwise may idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !req_taken) begin
      s_axis_tvalid <= 1'b1;
    end else begin
      req_taken = 1'b0;
      if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_q[0].func;
        s_axis_tdata  <= {5'd0, pending_q[0].den, pending_q[0].cbl, pending_q[0].cen,
                          pending_q[0].row, pending_q[0].col, pending_q[0].ch};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // strobe sink: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // monitor: predict on each accepted request, then check each strobe beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_strobes(pending_q[0]);
        pending_q.pop_front();
        req_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (strobe_q.size() == 0) begin
          note_error($sformatf("unexpected beat nibble %h tuser %b last %b",
                               m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          got_exp = strobe_q.pop_front();
          if (m_axis_tdata !== {4'h0, got_exp.nibble} ||
              m_axis_tuser !== {got_exp.clr_wait, got_exp.rs} ||
              m_axis_tlast !== got_exp.is_last) begin
            note_error($sformatf("exp data %h rs %b wait %b last %b, got data %h tuser %b last %b",
                                 {4'h0, got_exp.nibble}, got_exp.rs, got_exp.clr_wait,
                                 got_exp.is_last, m_axis_tdata, m_axis_tuser, m_axis_tlast));
          end
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [19:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    case (idx)
      CFG_LINE_COUNT: exp_lines = value[2:0];
      CFG_CHARS:      exp_chars = value[5:0];
      // tick counts leave the strobe contents unchanged
      default:        ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_lcd(logic [2:0] lines, logic [5:0] chars, logic [19:0] stb,
                         logic [19:0] clr);
    write_reg(CFG_LINE_COUNT, {17'd0, lines});
    write_reg(CFG_CHARS, {14'd0, chars});
    write_reg(CFG_STROBE_TICKS, stb);
    write_reg(CFG_CLEAR_TICKS, clr);
  endtask

  task automatic add_req(func_e f, logic [7:0] ch, logic [5:0] col, logic [1:0] row,
                         logic cen, logic cbl, logic den);
    lcd_req_t r;
    r.func = f;
    r.ch   = ch;
    r.col  = col;
    r.row  = row;
    r.cen  = cen;
    r.cbl  = cbl;
    r.den  = den;
    pending_q.push_back(r);
  endtask

  // half text traffic with wraps, half control requests
  task automatic add_random(int n);
    int pick;
    func_e f;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 30)      f = FUNC_WRAP;
      else if (pick < 50) f = FUNC_CHAR;
      else if (pick < 62) f = FUNC_GOTO;
      else if (pick < 70) f = FUNC_CURSOR;
      else if (pick < 78) f = FUNC_DISPLAY;
      else if (pick < 84) f = FUNC_CLEAR;
      else if (pick < 92) f = FUNC_RESTART;
      else                f = FUNC_INIT;
      add_req(f, 8'($urandom_range(255)), 6'($urandom_range(63)), 2'($urandom_range(3)),
              1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || strobe_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic run_phase(int src, int snk, int n);
    src_idle_pct  = src;
    snk_stall_pct = snk;
    add_random(n);
    drain();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: tiny wrap point so row wrap shows up quickly
    set_lcd(3'd2, 6'd2, 20'd1, 20'd0);
    add_req(FUNC_INIT, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_CHAR, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_CHAR, 8'hFF, 6'h3F, 2'd3, 1'b1, 1'b1, 1'b1);
    add_req(FUNC_WRAP, 8'h41, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_WRAP, 8'h42, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_WRAP, 8'h43, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_WRAP, 8'h44, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_GOTO, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_GOTO, 8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1);
    add_req(FUNC_GOTO, 8'h00, 6'd39, 2'd1, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_CLEAR, 8'h5A, 6'd5, 2'd2, 1'b1, 1'b0, 1'b1);
    add_req(FUNC_CURSOR, 8'h00, 6'd0, 2'd0, 1'b1, 1'b0, 1'b0);
    add_req(FUNC_DISPLAY, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b1);
    add_req(FUNC_CURSOR, 8'h00, 6'd0, 2'd0, 1'b1, 1'b1, 1'b0);
    add_req(FUNC_DISPLAY, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b1);
    add_req(FUNC_DISPLAY, 8'h00, 6'd0, 2'd0, 1'b1, 1'b1, 1'b0);
    add_req(FUNC_CURSOR, 8'h00, 6'd0, 2'd0, 1'b0, 1'b1, 1'b0);
    add_req(FUNC_DISPLAY, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b1);
    add_req(FUNC_WRAP, 8'h55, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_RESTART, 8'hAA, 6'd17, 2'd1, 1'b1, 1'b1, 1'b1);
    add_req(FUNC_WRAP, 8'h30, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_INIT, 8'hFF, 6'h3F, 2'd3, 1'b1, 1'b1, 1'b1);
    drain();

    set_lcd(3'd2, 6'd16, 20'($urandom_range(1048575, 1)), 20'($urandom_range(1048575)));
    run_phase(0, 0, 65);

    set_lcd(3'd4, 6'd1, 20'hFFFFF, 20'hFFFFF);
    run_phase(79, 0, 65);

    set_lcd(3'd1, 6'd40, 20'($urandom_range(1048575, 1)), 20'($urandom_range(1048575)));
    run_phase(0, 79, 65);

    // sink holds off while requests keep coming so the job queue fills
    set_lcd(3'd4, 6'd20, 20'd1, 20'd0);
    hold_left = 400;
    run_phase(0, 0, 65);

    set_lcd(3'd3, 6'd0, 20'($urandom_range(1048575, 1)), 20'($urandom_range(1048575)));
    run_phase(8, 8, 65);

    set_lcd(3'd7, 6'd63, 20'($urandom_range(1048575, 1)), 20'($urandom_range(1048575)));
    run_phase(8, 8, 30);
    set_lcd(3'd0, 6'd5, 20'd250000, 20'd500000);
    run_phase(0, 0, 30);

    repeat (20) @(negedge clk_i);
    if (err_cnt == 0 && strobe_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
